/* rtl/rgb_to_hsv_converter_assert.svh */
// Assertion macros used by the RGB to HSV converter checker.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// A property checked on every rising clock edge outside reset.
`define RHC_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define RHC_CHECK_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/rhc_pkg.sv */
// Shared constants, sector codes and inter-stage types of the RGB to HSV converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

	// Channel and hue fixed-point format.
	localparam int CHANNEL_BITS      = 8;
	localparam int HUE_FRACTION_BITS = 6;
	localparam int SECTOR_SPAN       = 60 << HUE_FRACTION_BITS;
	localparam int HUE_WRAP          = 6 * SECTOR_SPAN;
	localparam int GREEN_BASE        = 2 * SECTOR_SPAN;
	localparam int BLUE_BASE         = 4 * SECTOR_SPAN;
	localparam int HUE_BITS          = $clog2(HUE_WRAP);

	// Divider sizing: quotient bits cover both the hue fraction and the saturation.
	localparam int HUE_QUO_BITS = $clog2(SECTOR_SPAN + 1);
	localparam int QUO_BITS     = (HUE_QUO_BITS > CHANNEL_BITS) ? HUE_QUO_BITS : CHANNEL_BITS;
	localparam int NUM_BITS     = QUO_BITS + CHANNEL_BITS;

	// Sector that holds the maximum channel.
	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	// Side information that rides alongside the divider.
	typedef struct packed {
		logic [1:0]              sector;
		logic                    neg;
		logic                    gray;
		logic                    black;
		logic [CHANNEL_BITS-1:0] value;
	} rhc_tag_t;

	// Operands handed from the front end to the divider.
	typedef struct packed {
		logic [NUM_BITS-1:0]     hue_num;
		logic [CHANNEL_BITS-1:0] hue_den;
		logic [NUM_BITS-1:0]     sat_num;
		logic [CHANNEL_BITS-1:0] sat_den;
		rhc_tag_t                tag;
	} rhc_div_t;

	// Quotients handed from the divider to the finishing stage.
	typedef struct packed {
		logic [QUO_BITS-1:0] hue_quo;
		logic                hue_rem_nz;
		logic [QUO_BITS-1:0] sat_quo;
		rhc_tag_t            tag;
	} rhc_quo_t;

endpackage

`default_nettype wire

/* rtl/rgb_to_hsv_converter.sv */
// Top level of the RGB to HSV pixel converter.
// Depends on rhc_pkg, rhc_front, rhc_divider and rhc_finish.
//
//   Channel   Handshake                  Payload
//   pixel     pixel_valid, pixel_stall   red_level, green_level, blue_level
//   hsv       hsv_valid, hsv_stall       hue_angle, saturation_level, value_level
//
// One pixel enters every cycle while the output is not stalled.
// The divider, one quotient bit per stage, makes up most of the pipeline depth.
// Reset clears every valid bit; payload registers keep whatever they hold.
// A stall on hsv holds the output; empty stages still fill, so bubbles close up.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter
	import rhc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    pixel_valid,
	output logic                         pixel_stall,
	input  wire logic [CHANNEL_BITS-1:0] red_level,
	input  wire logic [CHANNEL_BITS-1:0] green_level,
	input  wire logic [CHANNEL_BITS-1:0] blue_level,
	output logic                         hsv_valid,
	input  wire logic                    hsv_stall,
	output logic [HUE_BITS-1:0]          hue_angle,
	output logic [CHANNEL_BITS-1:0]      saturation_level,
	output logic [CHANNEL_BITS-1:0]      value_level
);

	logic     front_ready;
	logic     front_valid;
	rhc_div_t front_data;
	logic     div_ready;
	logic     div_valid;
	rhc_quo_t div_data;
	logic     finish_ready;

	assign pixel_stall = !front_ready;

	// Extremes and operands.
	rhc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pixel_valid),
		.in_ready    (front_ready),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level),
		.out_valid   (front_valid),
		.out_ready   (div_ready),
		.out_data    (front_data)
	);

	// Hue fraction and saturation quotients.
	rhc_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (div_ready),
		.in_data   (front_data),
		.out_valid (div_valid),
		.out_ready (finish_ready),
		.out_data  (div_data)
	);

	// Hue assembly and output register.
	rhc_finish u_finish (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (div_valid),
		.in_ready         (finish_ready),
		.in_data          (div_data),
		.out_valid        (hsv_valid),
		.out_ready        (!hsv_stall),
		.hue_angle        (hue_angle),
		.saturation_level (saturation_level),
		.value_level      (value_level)
	);

endmodule

`default_nettype wire

/* rtl/rhc_front.sv */
// Front end: maximum, minimum, sector choice and the two division operands.
// Depends on rhc_pkg. Two register stages.
`timescale 1ns / 1ps
`default_nettype none

module rhc_front
	import rhc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [CHANNEL_BITS-1:0] red_level,
	input  wire logic [CHANNEL_BITS-1:0] green_level,
	input  wire logic [CHANNEL_BITS-1:0] blue_level,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output rhc_div_t                     out_data
);

	localparam int CHAN_FULL_C = (1 << CHANNEL_BITS) - 1;

	logic                    valid_s1;
	logic [CHANNEL_BITS-1:0] max_s1;
	logic [CHANNEL_BITS-1:0] min_s1;
	logic [1:0]              sector_s1;
	logic [CHANNEL_BITS-1:0] minuend_s1;
	logic [CHANNEL_BITS-1:0] subtrahend_s1;
	logic                    valid_s2;
	rhc_div_t                div_s2;
	logic                    ready_s1;
	logic                    ready_s2;

	logic [CHANNEL_BITS-1:0] max_c;
	logic [CHANNEL_BITS-1:0] min_c;
	logic [1:0]              sector_c;
	logic [CHANNEL_BITS-1:0] minuend_c;
	logic [CHANNEL_BITS-1:0] subtrahend_c;

	logic [CHANNEL_BITS-1:0] delta_c;
	logic                    neg_c;
	logic [CHANNEL_BITS-1:0] diff_c;

	// A stage takes new data when it is empty or its content moves on.
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Stage 1 logic: the first channel equal to the maximum picks the sector.
	always_comb begin
		if (red_level >= green_level && red_level >= blue_level) begin
			sector_c     = SEC_RED;
			max_c        = red_level;
			minuend_c    = green_level;
			subtrahend_c = blue_level;
		end else if (green_level >= blue_level) begin
			sector_c     = SEC_GREEN;
			max_c        = green_level;
			minuend_c    = blue_level;
			subtrahend_c = red_level;
		end else begin
			sector_c     = SEC_BLUE;
			max_c        = blue_level;
			minuend_c    = red_level;
			subtrahend_c = green_level;
		end
		min_c = red_level;
		if (green_level < min_c) begin
			min_c = green_level;
		end
		if (blue_level < min_c) begin
			min_c = blue_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			max_s1        <= max_c;
			min_s1        <= min_c;
			sector_s1     <= sector_c;
			minuend_s1    <= minuend_c;
			subtrahend_s1 <= subtrahend_c;
		end
	end

	// Stage 2 logic: delta, magnitude and sign of the sector difference.
	assign delta_c = max_s1 - min_s1;
	assign neg_c   = minuend_s1 < subtrahend_s1;
	assign diff_c  = neg_c ? (subtrahend_s1 - minuend_s1) : (minuend_s1 - subtrahend_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Constant scaling of both numerators.
	always_ff @(posedge clk) begin
		if (ready_s2) begin
			div_s2.hue_num      <= NUM_BITS'(diff_c) * NUM_BITS'(SECTOR_SPAN);
			div_s2.hue_den      <= delta_c;
			div_s2.sat_num      <= NUM_BITS'(delta_c) * NUM_BITS'(CHAN_FULL_C);
			div_s2.sat_den      <= max_s1;
			div_s2.tag.sector   <= sector_s1;
			div_s2.tag.neg      <= neg_c;
			div_s2.tag.gray     <= (delta_c == '0);
			div_s2.tag.black    <= (max_s1 == '0);
			div_s2.tag.value    <= max_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = div_s2;

endmodule

`default_nettype wire

/* rtl/rhc_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, two lanes side by side.
// Depends on rhc_pkg. The hue lane keeps its final remainder for floor rounding.
`timescale 1ns / 1ps
`default_nettype none

module rhc_divider
	import rhc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire rhc_div_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output rhc_quo_t      out_data
);

	logic                    valid_s   [QUO_BITS];
	logic [NUM_BITS-1:0]     hue_rem_s [QUO_BITS];
	logic [NUM_BITS-1:0]     sat_rem_s [QUO_BITS];
	logic [CHANNEL_BITS-1:0] hue_den_s [QUO_BITS];
	logic [CHANNEL_BITS-1:0] sat_den_s [QUO_BITS];
	logic [QUO_BITS-1:0]     hue_quo_s [QUO_BITS];
	logic [QUO_BITS-1:0]     sat_quo_s [QUO_BITS];
	rhc_tag_t                tag_s     [QUO_BITS];
	logic                    ready     [QUO_BITS+1];

	assign ready[QUO_BITS] = out_ready;
	assign in_ready        = ready[0];

	for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
		logic                    valid_in;
		logic [NUM_BITS-1:0]     hue_rem_in;
		logic [NUM_BITS-1:0]     sat_rem_in;
		logic [CHANNEL_BITS-1:0] hue_den_in;
		logic [CHANNEL_BITS-1:0] sat_den_in;
		logic [QUO_BITS-1:0]     hue_quo_in;
		logic [QUO_BITS-1:0]     sat_quo_in;
		rhc_tag_t                tag_in;
		logic [NUM_BITS-1:0]     hue_shift;
		logic [NUM_BITS-1:0]     sat_shift;
		logic                    hue_take;
		logic                    sat_take;

		// The first stage starts from the numerator with an empty quotient.
		if (i == 0) begin : g_first
			assign valid_in   = in_valid;
			assign hue_rem_in = in_data.hue_num;
			assign sat_rem_in = in_data.sat_num;
			assign hue_den_in = in_data.hue_den;
			assign sat_den_in = in_data.sat_den;
			assign hue_quo_in = '0;
			assign sat_quo_in = '0;
			assign tag_in     = in_data.tag;
		end else begin : g_next
			assign valid_in   = valid_s[i-1];
			assign hue_rem_in = hue_rem_s[i-1];
			assign sat_rem_in = sat_rem_s[i-1];
			assign hue_den_in = hue_den_s[i-1];
			assign sat_den_in = sat_den_s[i-1];
			assign hue_quo_in = hue_quo_s[i-1];
			assign sat_quo_in = sat_quo_s[i-1];
			assign tag_in     = tag_s[i-1];
		end

		// Trial subtraction of the divisor aligned to this quotient bit.
		assign hue_shift = NUM_BITS'(hue_den_in) << (QUO_BITS - 1 - i);
		assign sat_shift = NUM_BITS'(sat_den_in) << (QUO_BITS - 1 - i);
		assign hue_take  = hue_rem_in >= hue_shift;
		assign sat_take  = sat_rem_in >= sat_shift;

		assign ready[i] = !valid_s[i] || ready[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (ready[i]) begin
				valid_s[i] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ready[i]) begin
				hue_rem_s[i] <= hue_take ? (hue_rem_in - hue_shift) : hue_rem_in;
				sat_rem_s[i] <= sat_take ? (sat_rem_in - sat_shift) : sat_rem_in;
				hue_den_s[i] <= hue_den_in;
				sat_den_s[i] <= sat_den_in;
				hue_quo_s[i] <= {hue_quo_in[QUO_BITS-2:0], hue_take};
				sat_quo_s[i] <= {sat_quo_in[QUO_BITS-2:0], sat_take};
				tag_s[i]     <= tag_in;
			end
		end
	end

	// Last stage holds the finished quotients.
	assign out_valid           = valid_s[QUO_BITS-1];
	assign out_data.hue_quo    = hue_quo_s[QUO_BITS-1];
	assign out_data.hue_rem_nz = (hue_rem_s[QUO_BITS-1] != '0);
	assign out_data.sat_quo    = sat_quo_s[QUO_BITS-1];
	assign out_data.tag        = tag_s[QUO_BITS-1];

endmodule

`default_nettype wire

/* rtl/rhc_finish.sv */
// Finishing stage: sector offset, floor rounding, hue wrap and special cases.
// Depends on rhc_pkg. Its register is the output register of the converter.
`timescale 1ns / 1ps
`default_nettype none

module rhc_finish
	import rhc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire rhc_quo_t                 in_data,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [HUE_BITS-1:0]           hue_angle,
	output logic [CHANNEL_BITS-1:0]       saturation_level,
	output logic [CHANNEL_BITS-1:0]       value_level
);

	localparam int HW = HUE_BITS + 1;

	logic                    valid_q;
	logic [HUE_BITS-1:0]     hue_q;
	logic [CHANNEL_BITS-1:0] sat_q;
	logic [CHANNEL_BITS-1:0] value_q;

	logic [HW-1:0]           base_c;
	logic [HW-1:0]           mag_c;
	logic [HW-1:0]           sum_c;
	logic [HW-1:0]           wrapped_c;
	logic [HUE_BITS-1:0]     hue_c;
	logic [CHANNEL_BITS-1:0] sat_c;

	assign in_ready = !valid_q || out_ready;

	// Sector offset of the hue.
	always_comb begin
		case (in_data.tag.sector)
			SEC_RED:   base_c = '0;
			SEC_GREEN: base_c = HW'(GREEN_BASE);
			default:   base_c = HW'(BLUE_BASE);
		endcase
	end

	// A negative fraction rounds toward minus infinity, then wraps into range.
	assign mag_c     = HW'(in_data.hue_quo) + HW'(in_data.tag.neg & in_data.hue_rem_nz);
	assign sum_c     = in_data.tag.neg ? (base_c - mag_c) : (base_c + mag_c);
	assign wrapped_c = sum_c[HW-1] ? (sum_c + HW'(HUE_WRAP)) : sum_c;
	assign hue_c     = in_data.tag.gray ? '0 : wrapped_c[HUE_BITS-1:0];
	assign sat_c     = in_data.tag.black ? '0 : in_data.sat_quo[CHANNEL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			hue_q   <= hue_c;
			sat_q   <= sat_c;
			value_q <= in_data.tag.value;
		end
	end

	assign out_valid        = valid_q;
	assign hue_angle        = hue_q;
	assign saturation_level = sat_q;
	assign value_level      = value_q;

endmodule

`default_nettype wire

/* rtl/rhc_checker.sv */
// Port-level checks on the converter output, attached to the top level by bind.
// Depends on rhc_pkg and rgb_to_hsv_converter_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_hsv_converter_assert.svh"

module rhc_checker
	import rhc_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    hsv_valid,
	input wire logic                    hsv_stall,
	input wire logic [HUE_BITS-1:0]     hue_angle,
	input wire logic [CHANNEL_BITS-1:0] saturation_level,
	input wire logic [CHANNEL_BITS-1:0] value_level
);

	// A stalled transaction stays on the port unchanged.
	`RHC_CHECK_NEXT(a_hold, hsv_valid && hsv_stall, hsv_valid && $stable(hue_angle) && $stable(saturation_level) && $stable(value_level), "stalled hsv transaction changed")

	// The hue never reaches a full turn.
	`RHC_CHECK(a_hue_range, hsv_valid |-> (hue_angle < HUE_BITS'(HUE_WRAP)), "hue out of range")

	// Zero saturation means a gray pixel, whose hue is zero.
	`RHC_CHECK(a_gray, (hsv_valid && saturation_level == '0) |-> (hue_angle == '0), "gray pixel with nonzero hue")

	// A black pixel has neither saturation nor hue.
	`RHC_CHECK(a_black, (hsv_valid && value_level == '0) |-> (saturation_level == '0 && hue_angle == '0), "black pixel with color")

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.hsv_valid        (hsv_valid),
	.hsv_stall        (hsv_stall),
	.hue_angle        (hue_angle),
	.saturation_level (saturation_level),
	.value_level      (value_level)
);

`default_nettype wire
